// ----- rtl/u8ls_pkg.sv -----
// Shared types and constants for the UTF-8 lossy sanitizer.
package u8ls_pkg;

  localparam int unsigned MAX_RUN = 6;
  localparam int unsigned RUN_CNT_W = $clog2(MAX_RUN + 1);

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD_END  = 8'hF5;
  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F4   = 8'hF4;
  localparam logic [7:0] E0_MIN    = 8'hA0;
  localparam logic [7:0] ED_MAX    = 8'h9F;
  localparam logic [7:0] F0_MIN    = 8'h90;
  localparam logic [7:0] F4_MAX    = 8'h8F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_t;

  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]    cnt;
  } run_t;

endpackage

// ----- rtl/u8ls_decode.sv -----
// Sequence tracker: holds the pending sequence and forms the output run of one request.
module u8ls_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  u8ls_pkg::in_t req,
  output u8ls_pkg::run_t run
);
  import u8ls_pkg::*;

  logic [2:0][7:0] pend;
  logic [2:0][7:0] pend_next;
  logic [1:0]      pcount;
  logic [1:0]      pcount_next;
  logic [2:0]      elen;
  logic [2:0]      elen_next;

  logic [7:0]           b;
  logic [7:0]           lo;
  logic [7:0]           hi;
  logic                 fits;
  logic                 redo;
  logic [RUN_CNT_W-1:0] n;
  logic [MAX_RUN-1:0][7:0] bytes;

  assign b = req.in_byte;

  always_comb begin
    lo = CONT_MIN;
    hi = CONT_MAX;
    if (pcount == 2'd1) begin
      case (pend[0])
        LEAD_E0: lo = E0_MIN;
        LEAD_ED: hi = ED_MAX;
        LEAD_F0: lo = F0_MIN;
        LEAD_F4: hi = F4_MAX;
        default: begin
          lo = CONT_MIN;
          hi = CONT_MAX;
        end
      endcase
    end
  end

  assign fits = (b >= lo) && (b <= hi);

  always_comb begin
    n           = '0;
    bytes       = '0;
    pend_next   = pend;
    pcount_next = pcount;
    elen_next   = elen;
    redo        = 1'b0;

    if (pcount == 2'd0) begin
      redo = 1'b1;
    end else if (fits) begin
      if ({1'b0, pcount} + 3'd1 == elen) begin
        for (int k = 0; k < 3; k++) begin
          if (k < int'(pcount)) begin
            bytes[n] = pend[k];
            n = n + RUN_CNT_W'(1);
          end
        end
        bytes[n] = b;
        n = n + RUN_CNT_W'(1);
        pcount_next = '0;
        elen_next   = '0;
      end else begin
        pend_next[pcount] = b;
        pcount_next = pcount + 2'd1;
      end
    end else begin
      bytes[n] = REPL_B0;
      n = n + RUN_CNT_W'(1);
      bytes[n] = REPL_B1;
      n = n + RUN_CNT_W'(1);
      bytes[n] = REPL_B2;
      n = n + RUN_CNT_W'(1);
      pcount_next = '0;
      elen_next   = '0;
      redo = 1'b1;
    end

    if (redo) begin
      if (b < ASCII_END) begin
        bytes[n] = b;
        n = n + RUN_CNT_W'(1);
      end else if (b < LEAD2_MIN || b >= LEAD_END) begin
        bytes[n] = REPL_B0;
        n = n + RUN_CNT_W'(1);
        bytes[n] = REPL_B1;
        n = n + RUN_CNT_W'(1);
        bytes[n] = REPL_B2;
        n = n + RUN_CNT_W'(1);
      end else begin
        pend_next[0] = b;
        pcount_next  = 2'd1;
        elen_next    = (b < LEAD3_MIN) ? 3'd2 : (b < LEAD4_MIN) ? 3'd3 : 3'd4;
      end
    end

    if (req.in_last && pcount_next != 2'd0) begin
      bytes[n] = REPL_B0;
      n = n + RUN_CNT_W'(1);
      bytes[n] = REPL_B1;
      n = n + RUN_CNT_W'(1);
      bytes[n] = REPL_B2;
      n = n + RUN_CNT_W'(1);
      pcount_next = '0;
      elen_next   = '0;
    end
  end

  assign run.bytes = bytes;
  assign run.cnt   = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0;
      elen   <= '0;
    end else if (take) begin
      pcount <= pcount_next;
      elen   <= elen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend <= pend_next;
    end
  end

endmodule

// ----- rtl/utf8_lossy_sanitizer.sv -----
// Top level: byte-stream UTF-8 sanitizer with U+FFFD replacement of maximal subparts.
// The first output byte of a request is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while each yields at most one byte and dst_ready is high;
// a request that yields n bytes (up to six) holds the output register until all n are delivered.
// Reset (synchronous, active high) empties the output register and the pending sequence.
module utf8_lossy_sanitizer (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_ready,
  input  u8ls_pkg::in_t  src_data,
  output logic           dst_valid,
  input  logic           dst_ready,
  output u8ls_pkg::out_t dst_data
);
  import u8ls_pkg::*;

  run_t                    run;
  logic                    take;
  logic                    pop;
  logic [MAX_RUN-1:0][7:0] buf_bytes;
  logic [RUN_CNT_W-1:0]    buf_cnt;
  logic                    buf_end;

  u8ls_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (src_data),
    .run  (run)
  );

  assign dst_valid = (buf_cnt != '0);
  assign pop       = dst_valid && dst_ready;
  assign src_ready = (buf_cnt == '0) || ((buf_cnt == RUN_CNT_W'(1)) && dst_ready);
  assign take      = src_valid && src_ready;

  assign dst_data.out_byte   = buf_bytes[0];
  assign dst_data.run_last   = (buf_cnt == RUN_CNT_W'(1));
  assign dst_data.string_end = (buf_cnt == RUN_CNT_W'(1)) && buf_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
    end else if (take) begin
      buf_cnt <= run.cnt;
    end else if (pop) begin
      buf_cnt <= buf_cnt - RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf_bytes <= run.bytes;
      buf_end   <= src_data.in_last;
    end else if (pop) begin
      buf_bytes <= {8'h00, buf_bytes[MAX_RUN-1:1]};
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    buf_cnt <= RUN_CNT_W'(MAX_RUN))
    else $error("output run count out of range");

  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    take && run.cnt == '0 |=> !dst_valid)
    else $error("request with no output left output valid");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && buf_cnt == RUN_CNT_W'(1) && !take |=> !dst_valid)
    else $error("output valid after final byte of run");

  a_accept_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    take |-> (buf_cnt == '0) || (buf_cnt == RUN_CNT_W'(1) && pop))
    else $error("request accepted over undelivered output");
`endif

endmodule
